/* rtl/core/cprd_pkg.sv */
// Shared widths, reset values, register indexes and handshake structs for the period-to-reading block.
package cprd_pkg;

	localparam int TIME_W    = 32;
	localparam int MULT_W    = 16;
	localparam int COUNT_W   = 4;
	localparam int READING_W = 24;
	localparam int PROD_W    = TIME_W + MULT_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam int DIV_CNT_W = $clog2(TIME_W);
	localparam int MUL_CNT_W = $clog2(MULT_W);

	localparam logic [TIME_W-1:0]    VNUM_RESET = 32'd75942067;
	localparam logic [MULT_W-1:0]    VMUL_RESET = 16'd1000;
	localparam logic [TIME_W-1:0]    CNUM_RESET = 32'd6177645;
	localparam logic [COUNT_W-1:0]   PPM_RESET  = 4'd10;
	localparam logic [READING_W-1:0] READING_MAX = {READING_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VOLTAGE_NUMERATOR   = 2'd0,
		REG_VOLTAGE_MULTIPLIER  = 2'd1,
		REG_CURRENT_NUMERATOR   = 2'd2,
		REG_PERIODS_PER_MEASURE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic              start;
		logic [TIME_W-1:0] dividend;
		logic [TIME_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [TIME_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic              start;
		logic [TIME_W-1:0] multiplicand;
		logic [MULT_W-1:0] multiplier;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] product;
	} mul_rsp_t;

endpackage

/* rtl/core/cprd_div.sv */
// Restoring bit-serial divider: one quotient bit per cycle.
module cprd_div (
	input  logic              clk,
	input  logic              arst_n,
	input  cprd_pkg::div_req_t req,
	output cprd_pkg::div_rsp_t rsp
);

	logic                               busy_q;
	logic                               done_q;
	logic [cprd_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [cprd_pkg::TIME_W-1:0]        rem_q;
	logic [cprd_pkg::TIME_W-1:0]        quo_q;
	logic [cprd_pkg::TIME_W-1:0]        dvs_q;
	logic [cprd_pkg::TIME_W:0]          shifted;
	logic [cprd_pkg::TIME_W:0]          trial;

	assign shifted = {rem_q, quo_q[cprd_pkg::TIME_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == cprd_pkg::DIV_CNT_W'(cprd_pkg::TIME_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == cprd_pkg::DIV_CNT_W'(cprd_pkg::TIME_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Remainder and quotient share one shift path; the dividend drains out the top.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[cprd_pkg::TIME_W]) begin
				rem_q <= trial[cprd_pkg::TIME_W-1:0];
				quo_q <= {quo_q[cprd_pkg::TIME_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[cprd_pkg::TIME_W-1:0];
				quo_q <= {quo_q[cprd_pkg::TIME_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* rtl/core/cprd_mul.sv */
// Shift-and-add multiplier: one multiplier bit per cycle.
module cprd_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  cprd_pkg::mul_req_t req,
	output cprd_pkg::mul_rsp_t rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [cprd_pkg::MUL_CNT_W-1:0] cnt_q;
	logic [cprd_pkg::PROD_W-1:0]    acc_q;
	logic [cprd_pkg::PROD_W-1:0]    mcd_q;
	logic [cprd_pkg::MULT_W-1:0]    mpr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == cprd_pkg::MUL_CNT_W'(cprd_pkg::MULT_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == cprd_pkg::MUL_CNT_W'(cprd_pkg::MULT_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mcd_q <= {{cprd_pkg::MULT_W{1'b0}}, req.multiplicand};
			mpr_q <= req.multiplier;
		end else if (busy_q) begin
			if (mpr_q[0]) begin
				acc_q <= acc_q + mcd_q;
			end
			mcd_q <= {mcd_q[cprd_pkg::PROD_W-2:0], 1'b0};
			mpr_q <= {1'b0, mpr_q[cprd_pkg::MULT_W-1:1]};
		end
	end

	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule

/* rtl/core/capture_period_to_reading.sv */
// Top level: edge counting, span capture, divide/multiply sequencing and the result register.
// Usage
//   Input channel (in_valid/in_stall) carries one capture timestamp per beat plus
//   the voltage/current select. The first beat of a measurement latches the start
//   time; the following beats are counted, and the beat after periods_per_measure
//   periods closes the measurement. Only a closing beat with a non-zero span
//   produces a result beat on the output channel (out_valid/out_stall).
// Input flow
//   Non-closing beats are accepted back to back. A closing beat with a non-zero span
//   holds in_stall high while the serial datapath runs: first the divider (one
//   quotient bit per cycle), then the shift-and-add multiplier for voltage.
// Reset
//   arst_n clears the edge count, start time, sequencer and output valid, and
//   loads the configuration registers with their default values.
// Back-pressure
//   The output register holds its beat while out_stall is high; a finished result
//   waits in the sequencer, with the input stalled, until the register frees up.
// Configuration
//   Write cfg_we/cfg_index/cfg_data only while the block is idle.
module capture_period_to_reading (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cprd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cprd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [cprd_pkg::TIME_W-1:0]         capture_time,
	input  logic                                measure_voltage,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [cprd_pkg::READING_W-1:0]      reading,
	output logic                                is_voltage,
	output logic [cprd_pkg::TIME_W-1:0]         span_ticks
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [cprd_pkg::TIME_W-1:0]  vnum_q;
	logic [cprd_pkg::MULT_W-1:0]  vmul_q;
	logic [cprd_pkg::TIME_W-1:0]  cnum_q;
	logic [cprd_pkg::COUNT_W-1:0] ppm_q;

	// Measurement state
	logic [cprd_pkg::COUNT_W-1:0] edge_count_q;
	logic [cprd_pkg::TIME_W-1:0]  start_time_q;
	logic [cprd_pkg::TIME_W-1:0]  span_q;
	logic                         volt_q;
	logic [cprd_pkg::PROD_W-1:0]  value_q;

	// Output register
	logic                            out_valid_q;
	logic [cprd_pkg::READING_W-1:0]  reading_q;
	logic                            is_voltage_q;
	logic [cprd_pkg::TIME_W-1:0]     span_out_q;

	logic                         in_accept;
	logic                         closing;
	logic [cprd_pkg::TIME_W-1:0]  span;
	logic                         launch;
	logic                         out_free;
	logic                         load_out;
	logic [cprd_pkg::READING_W-1:0] value_sat;

	cprd_pkg::div_req_t div_req;
	cprd_pkg::div_rsp_t div_rsp;
	cprd_pkg::mul_req_t mul_req;
	cprd_pkg::mul_rsp_t mul_rsp;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	// A zero period count behaves like one: the beat after the start closes.
	assign closing = (edge_count_q != '0) && !(edge_count_q < ppm_q);
	assign span    = capture_time - start_time_q;
	assign launch  = in_accept && closing && (span != '0);

	assign out_free = !out_valid_q || !out_stall;
	assign load_out = (state_q == ST_DONE) && out_free;

	// Saturate: anything above the 24-bit range pins to full scale
	assign value_sat = (value_q[cprd_pkg::PROD_W-1:cprd_pkg::READING_W] != '0) ?
		cprd_pkg::READING_MAX : value_q[cprd_pkg::READING_W-1:0];

	// Divider takes the selected numerator over the span captured on the closing beat
	assign div_req.start    = launch;
	assign div_req.dividend = measure_voltage ? vnum_q : cnum_q;
	assign div_req.divisor  = span;

	assign mul_req.start        = (state_q == ST_DIV) && div_rsp.done && volt_q;
	assign mul_req.multiplicand = div_rsp.quotient;
	assign mul_req.multiplier   = vmul_q;

	cprd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	cprd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// Configuration writes; the four registers use every index, so the default arm is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vnum_q <= cprd_pkg::VNUM_RESET;
			vmul_q <= cprd_pkg::VMUL_RESET;
			cnum_q <= cprd_pkg::CNUM_RESET;
			ppm_q  <= cprd_pkg::PPM_RESET;
		end else if (cfg_we) begin
			unique case (cprd_pkg::cfg_reg_t'(cfg_index))
				cprd_pkg::REG_VOLTAGE_NUMERATOR: begin
					vnum_q <= cfg_data[cprd_pkg::TIME_W-1:0];
				end
				cprd_pkg::REG_VOLTAGE_MULTIPLIER: begin
					vmul_q <= cfg_data[cprd_pkg::MULT_W-1:0];
				end
				cprd_pkg::REG_CURRENT_NUMERATOR: begin
					cnum_q <= cfg_data[cprd_pkg::TIME_W-1:0];
				end
				cprd_pkg::REG_PERIODS_PER_MEASURE: begin
					ppm_q <= cfg_data[cprd_pkg::COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Edge counting: latch start on the first beat, advance on the middle ones,
	// drop back to zero on the closing beat whether or not a result follows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= '0;
			start_time_q <= '0;
		end else if (in_accept) begin
			if (edge_count_q == '0) begin
				start_time_q <= capture_time;
				edge_count_q <= cprd_pkg::COUNT_W'(1);
			end else if (!closing) begin
				edge_count_q <= edge_count_q + 1'b1;
			end else begin
				edge_count_q <= '0;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (launch) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= volt_q ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					if (mul_rsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working payload
	always_ff @(posedge clk) begin
		if (launch) begin
			span_q <= span;
			volt_q <= measure_voltage;
		end
		if ((state_q == ST_DIV) && div_rsp.done && !volt_q) begin
			value_q <= {{cprd_pkg::MULT_W{1'b0}}, div_rsp.quotient};
		end else if ((state_q == ST_MUL) && mul_rsp.done) begin
			value_q <= mul_rsp.product;
		end
	end

	// Output register: hold while stalled, load from the sequencer when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			reading_q    <= value_sat;
			is_voltage_q <= volt_q;
			span_out_q   <= span_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign reading    = reading_q;
	assign is_voltage = is_voltage_q;
	assign span_ticks = span_out_q;

	// The divider only finishes while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide phase");

	// The multiplier only finishes while the sequencer waits for it
	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == ST_MUL))
		else $error("multiplier finished outside the multiply phase");

	// A result beat only appears after the sequencer reached its final phase
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("output beat raised without a finished result");

	// While a measurement is being worked on, the edge count has been cleared
	a_count_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (edge_count_q == '0))
		else $error("edge count not cleared during computation");

	// The multiplier runs only for voltage readings
	a_mul_voltage_only: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |-> volt_q)
		else $error("multiplier started for a current reading");

endmodule

/* tb/sv/tb_capture_period_to_reading.sv */
// Self-checking testbench for capture_period_to_reading: queued capture beats, predicted readings.
module tb_capture_period_to_reading;

	import cprd_pkg::*;

	// Quiet cycles tolerated before the run is declared hung. The slowest correct stretch is the
	// long receiver hold-off (HOLD_CYCLES) plus one voltage closing beat.
	localparam int STALL_LIMIT  = 4000;
	// Cycles allowed after the last expected reading for a result-free closing beat to finish.
	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_CYCLES  = 500;
	localparam int RANDOM_BEATS = 1150;
	localparam int IDLE_PCT     = 23;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic              volt;
	} capture_t;

	typedef struct packed {
		logic [READING_W-1:0] reading;
		logic                 volt;
		logic [TIME_W-1:0]    span;
	} reading_t;

	// Block ports; every input starts at a known value.
	logic                  clk             = 1'b0;
	logic                  arst_n          = 1'b0;
	logic                  cfg_we          = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index       = '0;
	logic [CFG_DATA_W-1:0] cfg_data        = '0;
	logic                  in_valid        = 1'b0;
	logic                  in_stall;
	logic [TIME_W-1:0]     capture_time    = '0;
	logic                  measure_voltage = 1'b0;
	logic                  out_valid;
	logic                  out_stall       = 1'b0;
	logic [READING_W-1:0]  reading;
	logic                  is_voltage;
	logic [TIME_W-1:0]     span_ticks;

	// Shadow configuration and measurement state, kept in step with the block.
	logic [TIME_W-1:0]  vnum = VNUM_RESET;
	logic [MULT_W-1:0]  vmul = VMUL_RESET;
	logic [TIME_W-1:0]  cnum = CNUM_RESET;
	logic [COUNT_W-1:0] ppm  = PPM_RESET;
	logic [COUNT_W-1:0] edge_cnt    = '0;
	logic [TIME_W-1:0]  start_stamp = '0;

	capture_t capture_queue[$];
	reading_t pending_readings[$];

	int unsigned beats_queued  = 0;
	int unsigned beats_in      = 0;
	int unsigned readings_seen = 0;
	int unsigned zero_spans    = 0;
	int unsigned mismatches    = 0;
	int unsigned phases        = 0;
	int unsigned quiet_cycles  = 0;
	int unsigned idle_pct      = IDLE_PCT;
	bit          hold_arm      = 1'b0;
	bit          hold_taken    = 1'b0;
	int unsigned hold_left     = 0;

	capture_period_to_reading dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.capture_time    (capture_time),
		.measure_voltage (measure_voltage),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.reading         (reading),
		.is_voltage      (is_voltage),
		.span_ticks      (span_ticks)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Advance the shadow edge counter for one accepted capture beat and, on a closing beat with a
	// non-zero span, queue the reading the block must produce.
	task automatic compute_reading(input logic [TIME_W-1:0] stamp, input logic volt);
		logic [TIME_W-1:0] span;
		logic [PROD_W-1:0] prod;
		reading_t          r;
		if (edge_cnt == '0) begin
			start_stamp = stamp;
			edge_cnt    = 4'd1;
		end else if (edge_cnt < ppm) begin
			edge_cnt = edge_cnt + 4'd1;
		end else begin
			// A period count of zero lands here on the first beat after the start, like one.
			edge_cnt = '0;
			span     = stamp - start_stamp;
			if (span == '0) begin
				zero_spans++;
			end else begin
				// Divide first, then widen to the full product so the voltage path never wraps.
				if (volt)
					prod = PROD_W'(vnum / span) * PROD_W'(vmul);
				else
					prod = PROD_W'(cnum / span);
				r.reading = (prod > PROD_W'(READING_MAX)) ? READING_MAX : prod[READING_W-1:0];
				r.volt    = volt;
				r.span    = span;
				pending_readings.push_back(r);
			end
		end
	endtask

	// Driver: retire the beat on the bus when accepted, then offer the next one or idle.
	always @(posedge clk) begin
		capture_t beat;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				compute_reading(capture_time, measure_voltage);
				beats_in++;
			end
			// A stalled beat stays on the bus untouched.
			if (!in_valid || !in_stall) begin
				if (capture_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					beat = capture_queue.pop_front();
					in_valid        <= 1'b1;
					capture_time    <= beat.stamp;
					measure_voltage <= beat.volt;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted reading against the oldest prediction, and drive out_stall,
	// including one long hold-off so the block backs up into its input.
	always @(posedge clk) begin
		reading_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				readings_seen++;
				if (pending_readings.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected reading %0d volt %0b span %0d",
							reading, is_voltage, span_ticks);
					mismatches++;
				end else begin
					want = pending_readings.pop_front();
					if (reading !== want.reading || is_voltage !== want.volt ||
							span_ticks !== want.span) begin
						if (mismatches < 10)
							$display("reading mismatch: want %0d/%0b/%0d got %0d/%0b/%0d",
								want.reading, want.volt, want.span,
								reading, is_voltage, span_ticks);
						mismatches++;
					end
				end
			end
			if (hold_arm && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_left  <= HOLD_CYCLES;
				out_stall  <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < idle_pct);
			end
		end
	end

	// Watchdog: end the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic push_capture(input logic [TIME_W-1:0] stamp, input logic volt);
		capture_queue.push_back('{stamp: stamp, volt: volt});
		beats_queued++;
	endtask

	task automatic push_pair(input logic [TIME_W-1:0] first, input logic [TIME_W-1:0] last,
			input logic volt);
		push_capture(first, volt);
		push_capture(last, volt);
	endtask

	// Wait until every queued beat is in and every reading out, then let a result-free
	// closing beat run to completion.
	task automatic settle();
		while (beats_in != beats_queued || pending_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_VOLTAGE_NUMERATOR:   vnum = value;
			REG_VOLTAGE_MULTIPLIER:  vmul = value[MULT_W-1:0];
			REG_CURRENT_NUMERATOR:   cnum = value;
			REG_PERIODS_PER_MEASURE: ppm  = value[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	// Load all four registers; upper data bits beyond a register's width must be dropped.
	task automatic configure(input logic [31:0] vn, input logic [31:0] vm, input logic [31:0] cn,
			input logic [31:0] pp);
		write_reg(REG_VOLTAGE_NUMERATOR, vn);
		write_reg(REG_VOLTAGE_MULTIPLIER, vm);
		write_reg(REG_CURRENT_NUMERATOR, cn);
		write_reg(REG_PERIODS_PER_MEASURE, pp);
		@(posedge clk);
		cfg_we <= 1'b0;
		phases++;
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0:       return 32'h0000_0000;
			1:       return 32'h0000_0001;
			2:       return 32'hFFFF_FFFF;
			default: return $urandom >> $urandom_range(0, 12);
		endcase
	endfunction

	function automatic logic [31:0] pick_span();
		case ($urandom_range(0, 11))
			0:       return 32'h0000_0000;
			1:       return 32'h0000_0001;
			2:       return 32'hFFFF_FFFF;
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	// One well-formed measurement with random content: start beat, intermediate beats (now and
	// then plain noise, which the block only counts), closing beat; sometimes a stray extra beat.
	task automatic queue_measurement();
		logic [TIME_W-1:0] start;
		logic [TIME_W-1:0] span;
		int unsigned       periods;
		start   = $urandom;
		span    = pick_span();
		periods = (ppm == '0) ? 1 : ppm;
		push_capture(start, 1'($urandom_range(0, 1)));
		for (int unsigned i = 1; i < periods; i++) begin
			if ($urandom_range(0, 9) == 0)
				push_capture($urandom, 1'($urandom_range(0, 1)));
			else
				push_capture(start + (span / periods) * i, 1'($urandom_range(0, 1)));
		end
		push_capture(start + span, 1'($urandom_range(0, 1)));
		// Knock the sequence out of step with the counter.
		if ($urandom_range(0, 9) == 0)
			push_capture($urandom, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		int unsigned target;
		logic [31:0] mult;
		logic [31:0] periods;

		// Hold reset, then release it away from the rising edge.
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset values: one full ten-period voltage measurement.
		for (int i = 0; i < 10; i++)
			push_capture(32'h1000_0000 + 32'h1000 * i, 1'b0);
		push_capture(32'h1001_0000, 1'b1);
		settle();

		// One-period measurements across the edge cases.
		configure(VNUM_RESET, {16'hFFFF, VMUL_RESET}, CNUM_RESET, 32'hFFFF_FFF1);
		push_pair(32'h0000_0000, 32'h0000_0000, 1'b1);   // zero span: no reading
		push_pair(32'hFFFF_FFF0, 32'h0000_0010, 1'b0);   // timer wraps between the edges
		push_pair(32'h1234_5678, 32'h1234_5679, 1'b1);   // shortest span, voltage saturates
		push_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);   // longest span, current
		push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1);   // longest span, voltage
		settle();

		// Zero numerators and multiplier, and a period count of zero.
		configure(32'h0000_0000, 32'hA5A5_0000, 32'h0000_0000, 32'h5A5A_5A50);
		push_pair(32'h0000_0005, 32'h0000_0006, 1'b1);
		push_pair(32'h0000_0007, 32'h0000_0009, 1'b0);
		settle();

		// Largest numerators and multiplier: saturating voltage, small current.
		configure(32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
		push_pair(32'h0000_0010, 32'h0001_0010, 1'b1);
		push_pair(32'h0000_0000, 32'h1000_0000, 1'b0);
		settle();

		// Random phases: fresh settings each time, one calm phase, one with the long hold-off.
		target = beats_queued + RANDOM_BEATS;
		for (int p = 0; beats_queued < target; p++) begin
			case ($urandom_range(0, 7))
				0:       mult = 32'h0000_0000;
				1:       mult = 32'h0000_0001;
				2:       mult = 32'h0000_FFFF;
				default: mult = $urandom_range(1, 65535);
			endcase
			mult[31:16] = 16'($urandom);
			periods = $urandom;
			if (p == 0)
				periods[3:0] = 4'd15;
			else if (p == 4 || $urandom_range(0, 2) == 0)
				periods[3:0] = 4'($urandom_range(0, 2));
			// Keep the hold-off phase dense in readings so the block backs up.
			if (p == 4)
				periods[3:0] = 4'd1;
			idle_pct = (p == 2) ? 0 : IDLE_PCT;
			configure(pick_operand(), mult, pick_operand(), periods);
			if (p == 4)
				hold_arm = 1'b1;
			repeat ((p == 4) ? 40 : $urandom_range(4, 12))
				queue_measurement();
			settle();
		end

		$display("ran %0d capture beats over %0d register settings", beats_in, phases);
		$display("checked %0d readings; %0d closing beats had a zero span", readings_seen,
			zero_spans);
		if (mismatches == 0 && pending_readings.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
rtl/core/cprd_pkg.sv
rtl/core/cprd_div.sv
rtl/core/cprd_mul.sv
rtl/core/capture_period_to_reading.sv
tb/sv/tb_capture_period_to_reading.sv
